// ===== rtl/core/sslu_pkg.sv =====
// Shared types and codes for the scoped symbol stack lookup unit.
`timescale 1ns / 1ps
`default_nettype none

package sslu_pkg;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 16;
  localparam int COUNT_W  = 7;
  localparam int OCC_W    = 7;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_UNDER = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  remove_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                found;
    logic [HANDLE_W-1:0] found_handle;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the incoming item
    logic exec;        // finish a non-search operation
    logic scan_start;  // point the search at the newest entry
    logic scan_run;    // issue one read per cycle
    logic scan_end;    // capture the search result
    logic emit;        // move the result to the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_lookup;
    logic empty;
    logic hit;
    logic bottom;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/scoped_symbol_stack_lookup_unit.sv =====
// Insert and remove are executed after item accept, and their result is then moved to the output register;
// a new item is accepted only while the previous result is handed off, not before.
// A lookup on a non-empty stack then reads entries one at a time from the newest down until a match or
// the bottom, since the entry memory has a single registered read port.
// Synchronous reset empties the stack and clears the controller and output valid;
// the entry memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module scoped_symbol_stack_lookup_unit #(
  parameter int DEPTH     = 64,
  parameter int KEY_BYTES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sslu_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sslu_pkg::out_item_t     out_data
);
  import sslu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sslu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  sslu_dp #(
    .DEPTH     (DEPTH),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sslu_ctrl.sv =====
// Sequencer for the symbol stack: item intake, search control and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module sslu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output sslu_pkg::cmd_t     cmd,
  input  wire sslu_pkg::sts_t sts
);
  import sslu_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_lookup && !sts.empty) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit || sts.bottom) begin
          cmd.scan_end = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          in_stall = 1'b0;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_EXEC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_scan_needs_entries: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> (sts.is_lookup && !sts.empty))
    else $error("search started without entries");

  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && (sts.hit || sts.bottom)) |=> state == S_DONE)
    else $error("search end not followed by result hand-off");

  a_load_only_when_open: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE || (state == S_DONE && sts.out_free)))
    else $error("item taken while busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sslu_dp.sv =====
// Symbol stack datapath: entry memory, top count, search pointer and result registers.
`timescale 1ns / 1ps
`default_nettype none

module sslu_dp #(
  parameter int DEPTH     = 64,
  parameter int KEY_BYTES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sslu_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sslu_pkg::out_item_t     out_data,
  input  wire sslu_pkg::cmd_t     cmd,
  output sslu_pkg::sts_t          sts
);
  import sslu_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  entry_t    mem [DEPTH];
  entry_t    rd_data;
  in_item_t  op;
  out_item_t res, res_next;

  logic [CW-1:0] top, top_next, top_m1;
  logic [AW-1:0] ptr;
  logic          live;
  logic          rd_valid;
  logic          rd_bottom;
  logic          full, under, hit;
  logic [MW-1:0] rc_w, top_w, occ_w;

  // Equal up to and including the first zero byte, within KEY_BYTES bytes.
  function automatic logic keys_equal(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    logic eq;
    logic done;
    eq   = 1'b1;
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i < KEY_BYTES && !done) begin
        if (a[8*i +: 8] != b[8*i +: 8]) begin
          eq   = 1'b0;
          done = 1'b1;
        end else if (a[8*i +: 8] == 8'd0) begin
          done = 1'b1;
        end
      end
    end
    return eq;
  endfunction

  assign full   = top >= CW'(DEPTH);
  assign rc_w   = MW'(op.remove_count);
  assign top_w  = MW'(top);
  assign under  = rc_w > top_w;
  assign top_m1 = top - CW'(1);
  assign hit    = rd_valid && keys_equal(op.key, rd_data.key);

  always_comb begin
    top_next = top;
    if (cmd.exec) begin
      unique case (op.kind)
        KIND_INSERT: if (!full) top_next = top + CW'(1);
        KIND_REMOVE: top_next = under ? '0 : top - CW'(op.remove_count);
        default:     top_next = top;
      endcase
    end
  end

  assign occ_w = MW'(top_next);

  always_comb begin
    res_next              = '0;
    res_next.status       = STAT_OK;
    res_next.occupancy    = occ_w[OCC_W-1:0];
    if (cmd.scan_end) begin
      res_next.found        = hit;
      res_next.found_handle = hit ? rd_data.handle : '0;
    end else begin
      unique case (op.kind)
        KIND_INSERT: if (full) res_next.status = STAT_FULL;
        KIND_REMOVE: if (under) res_next.status = STAT_UNDER;
        default:     res_next.status = STAT_OK;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      top       <= '0;
      live      <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      top <= top_next;
      if (cmd.scan_start) begin
        live     <= 1'b1;
        rd_valid <= 1'b0;
      end else if (cmd.scan_run) begin
        rd_valid <= live;
        if (live && ptr == '0) live <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) op <= in_data;
    if (cmd.exec || cmd.scan_end) res <= res_next;
    if (cmd.emit) out_data <= res;
    if (cmd.scan_start) begin
      ptr <= top_m1[AW-1:0];
    end else if (cmd.scan_run && live) begin
      rd_bottom <= (ptr == '0);
      if (ptr != '0) ptr <= ptr - AW'(1);
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && op.kind == KIND_INSERT && !full) begin
      mem[top[AW-1:0]] <= '{key: op.key, handle: op.handle};
    end
    rd_data <= mem[ptr];
  end

  assign sts.is_lookup = (op.kind == KIND_LOOKUP);
  assign sts.empty     = (top == '0);
  assign sts.hit       = hit;
  assign sts.bottom    = rd_valid && rd_bottom;
  assign sts.out_free  = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_top_bounded: assert property (@(posedge clk) disable iff (rst)
    top <= CW'(DEPTH))
    else $error("entry count above depth");

  a_found_is_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.found) |-> out_data.status == STAT_OK)
    else $error("match reported with error status");

  a_miss_zero_handle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> out_data.found_handle == '0)
    else $error("nonzero handle without match");

  a_under_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op.kind == KIND_REMOVE && under) |=> top == '0)
    else $error("underflow did not empty the stack");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_scoped_symbol_stack_lookup_unit.sv =====
// Self-checking testbench for the scoped symbol stack lookup unit.
`timescale 1ns / 1ps

module tb_scoped_symbol_stack_lookup_unit;
  import sslu_pkg::*;

  localparam int DEPTH     = 64;
  localparam int N_ITEMS   = 800;
  localparam int N_NAMES   = 12;
  localparam int WDOG_MAX  = 3000;
  localparam int DRAIN     = DEPTH + 16;
  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct {
    logic [1:0]          kind;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  cnt;
    bit                  typed;
    logic [1:0]          status;
    logic                found;
    logic [HANDLE_W-1:0] found_handle;
    logic [OCC_W-1:0]    occupancy;
  } sym_op_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // predicted stack contents
  logic [KEY_W-1:0]    sym_key    [DEPTH];
  logic [HANDLE_W-1:0] sym_handle [DEPTH];
  int                  sym_count;

  out_item_t   pending_q [$];
  out_item_t   want;
  logic [KEY_W-1:0] names [N_NAMES];
  sym_op_row_t op_table [19];

  bit quiet;
  int err_cnt, n_sent, n_hit, n_miss, n_full, n_under, peak_occ, idle_cycles;

  scoped_symbol_stack_lookup_unit #(
    .DEPTH     (DEPTH),
    .KEY_BYTES (8)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // identifiers are equal up to and including the first zero byte
  function automatic bit key_match(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    int i;
    for (i = 0; i < 8; i++) begin
      if (a[8*i +: 8] != b[8*i +: 8]) return 1'b0;
      if (a[8*i +: 8] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t step_symbols(in_item_t it);
    out_item_t r;
    int i;
    r = '0;
    case (it.kind)
      KIND_INSERT: begin
        if (sym_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          sym_key[sym_count]    = it.key;
          sym_handle[sym_count] = it.handle;
          sym_count++;
        end
      end
      KIND_LOOKUP: begin
        for (i = sym_count - 1; i >= 0 && !r.found; i--) begin
          if (key_match(it.key, sym_key[i])) begin
            r.found        = 1'b1;
            r.found_handle = sym_handle[i];
          end
        end
      end
      KIND_REMOVE: begin
        if (int'(it.remove_count) > sym_count) begin
          sym_count = 0;
          r.status  = STAT_UNDER;
        end else begin
          sym_count -= int'(it.remove_count);
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(sym_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] make_name(int len);
    logic [KEY_W-1:0] k;
    int i;
    k = '0;
    for (i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // junk after the terminator must not affect a match
  function automatic logic [KEY_W-1:0] pad_garbage(logic [KEY_W-1:0] k);
    int i;
    bit ended;
    ended = 1'b0;
    for (i = 0; i < 8; i++) begin
      if (ended) k[8*i +: 8] = 8'($urandom);
      else if (k[8*i +: 8] == 8'h00) ended = 1'b1;
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic report(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // caller is at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    int gap;
    out_item_t pred;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = step_symbols(it);
    pending_q.push_back(typed ? typed_res : pred);
    n_sent++;
    if (it.kind == KIND_LOOKUP) begin
      if (pred.found) n_hit++;
      else n_miss++;
    end
    if (pred.status == STAT_FULL) n_full++;
    if (pred.status == STAT_UNDER) n_under++;
    if (sym_count > peak_occ) peak_occ = sym_count;
    @(negedge clk);
  endtask

  task automatic send(logic [1:0] kind, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] hdl,
                      int cnt);
    in_item_t it;
    it.kind         = kind;
    it.key          = key;
    it.handle       = hdl;
    it.remove_count = COUNT_W'(cnt);
    send_item(it, 1'b0, '0);
  endtask

  // drop valid so the last item is not taken twice, then let everything drain
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // open a scope, look names up, then usually close it
  task automatic run_scope();
    int n, m, j, r;
    logic [KEY_W-1:0] k;
    n = $urandom_range(1, 8);
    for (j = 0; j < n; j++)
      send(KIND_INSERT, names[$urandom_range(0, N_NAMES-1)], 16'($urandom),
           $urandom_range(0, 64));
    m = $urandom_range(1, 8);
    for (j = 0; j < m; j++) begin
      r = $urandom_range(0, 9);
      if (r < 6) k = pad_garbage(names[$urandom_range(0, N_NAMES-1)]);
      else if (r < 8) k = names[$urandom_range(0, N_NAMES-1)];
      else if (r == 8 && sym_count > 0) k = sym_key[$urandom_range(0, sym_count-1)];
      else k = rand_key();
      send(KIND_LOOKUP, k, 16'($urandom), $urandom_range(0, 64));
    end
    r = $urandom_range(0, 99);
    if (r < 60 || (r < 75 && sym_count > 40))
      send(KIND_REMOVE, rand_key(), 16'($urandom), n);
    else if (r < 90)
      send(KIND_REMOVE, rand_key(), 16'($urandom), $urandom_range(0, sym_count));
    else if (r < 95)
      send(KIND_REMOVE, rand_key(), 16'($urandom),
           (sym_count + 3 > 64) ? 64 : sym_count + $urandom_range(1, 3));
  endtask

  task automatic run_noise();
    int n, j;
    n = $urandom_range(5, 15);
    for (j = 0; j < n; j++)
      send(2'($urandom_range(0, 3)),
           ($urandom_range(0, 3) == 0) ? names[$urandom_range(0, N_NAMES-1)] : rand_key(),
           16'($urandom), $urandom_range(0, 64));
  endtask

  // fill the store, push past full, scan the deepest entries, then drop
  task automatic run_fill();
    int j;
    while (sym_count < DEPTH)
      send(KIND_INSERT, make_name($urandom_range(1, 8)), 16'($urandom),
           $urandom_range(0, 64));
    for (j = 0; j < $urandom_range(1, 2); j++)
      send(KIND_INSERT, rand_key(), 16'($urandom), $urandom_range(0, 64));
    send(KIND_LOOKUP, pad_garbage(sym_key[0]), 16'($urandom), 0);
    send(KIND_LOOKUP, sym_key[DEPTH-1], 16'($urandom), 0);
    send(KIND_LOOKUP, rand_key(), 16'($urandom), 0);
    send(KIND_REMOVE, rand_key(), 16'($urandom),
         ($urandom_range(0, 1) == 0) ? DEPTH : $urandom_range(0, 64));
  endtask

  initial begin
    out_item_t res;
    in_item_t  it;
    int i, j, phase, r;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    quiet     = 1'b0;
    sym_count = 0;

    op_table = '{
      '{KIND_LOOKUP, 64'h0, 16'h0, 7'd0, 1, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_REMOVE, 64'h0, 16'h0, 7'd0, 1, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_REMOVE, 64'h0, 16'h0, 7'd64, 1, STAT_UNDER, 1'b0, 16'h0, 7'd0},
      '{KIND_NOP, '1, 16'hFFFF, 7'd64, 1, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_INSERT, '1, 16'hFFFF, 7'd0, 1, STAT_OK, 1'b0, 16'h0, 7'd1},
      '{KIND_INSERT, 64'h0, 16'h0, 7'd0, 1, STAT_OK, 1'b0, 16'h0, 7'd2},
      '{KIND_INSERT, 64'h61, 16'h1234, 7'd0, 1, STAT_OK, 1'b0, 16'h0, 7'd3},
      '{KIND_LOOKUP, '1, 16'h0, 7'd0, 1, STAT_OK, 1'b1, 16'hFFFF, 7'd3},
      '{KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 16'h0, 7'd0, 0, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_INSERT, 64'h61, 16'h5678, 7'd0, 0, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_LOOKUP, 64'hDEAD_BEEF_0000_0061, 16'h0, 7'd0, 0, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_LOOKUP, 64'h6261, 16'h0, 7'd0, 0, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_REMOVE, 64'h0, 16'h0, 7'd1, 0, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_LOOKUP, 64'h61, 16'h0, 7'd0, 0, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_INSERT, 64'h0123_4567_89AB_CDEF, 16'h8001, 7'd0, 0, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_LOOKUP, 64'h0123_4567_89AB_CDEF, 16'h0, 7'd0, 0, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_LOOKUP, 64'h1123_4567_89AB_CDEF, 16'h0, 7'd0, 0, STAT_OK, 1'b0, 16'h0, 7'd0},
      '{KIND_REMOVE, 64'h0, 16'h0, 7'd64, 1, STAT_UNDER, 1'b0, 16'h0, 7'd0},
      '{KIND_NOP, 64'h0, 16'h0, 7'd0, 1, STAT_OK, 1'b0, 16'h0, 7'd0}
    };

    // odd slots hold a one-char-shorter prefix of the name before them
    for (i = 0; i < N_NAMES; i++) begin
      if (i % 2 == 0) begin
        names[i] = make_name($urandom_range(2, 8));
      end else begin
        names[i] = names[i-1];
        for (j = 7; j >= 0; j--)
          if (names[i][8*j +: 8] != 8'h00 && names[i] == names[i-1])
            names[i][8*j +: 8] = 8'h00;
      end
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (op_table[i]) begin
      it.kind           = op_table[i].kind;
      it.key            = op_table[i].key;
      it.handle         = op_table[i].handle;
      it.remove_count   = op_table[i].cnt;
      res.status        = op_table[i].status;
      res.found         = op_table[i].found;
      res.found_handle  = op_table[i].found_handle;
      res.occupancy     = op_table[i].occupancy;
      send_item(it, op_table[i].typed, res);
    end

    run_fill();
    phase = 0;
    while (n_sent < N_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 72) run_scope();
      else if (r < 97) run_noise();
      else run_fill();
      phase++;
      if (phase % 12 == 0) wait_all_results();
    end
    quiet = 1'b0;

    wait_all_results();
    repeat (DRAIN) @(negedge clk);
    $display("%0d items: %0d lookup hits, %0d misses, %0d full refusals, %0d underflows",
             n_sent, n_hit, n_miss, n_full, n_under);
    $display("peak occupancy %0d of %0d, %0d mismatches", peak_occ, DEPTH, err_cnt);
    if (err_cnt == 0) begin
      $display("** scoped_symbol_stack_lookup_unit: PASSED **");
    end else begin
      $display("** scoped_symbol_stack_lookup_unit: FAILED **");
    end
    $finish;
  end

  // result back-pressure
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result st=%0d f=%0b h=%h occ=%0d", out_data.status,
                         out_data.found, out_data.found_handle, out_data.occupancy));
      end else begin
        want = pending_q.pop_front();
        if (out_data.status !== want.status || out_data.found !== want.found ||
            out_data.found_handle !== want.found_handle ||
            out_data.occupancy !== want.occupancy)
          report($sformatf("exp st=%0d f=%0b h=%h occ=%0d, got st=%0d f=%0b h=%h occ=%0d",
                           want.status, want.found, want.found_handle, want.occupancy,
                           out_data.status, out_data.found, out_data.found_handle,
                           out_data.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WDOG_MAX) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 WDOG_MAX, pending_q.size());
        $display("** scoped_symbol_stack_lookup_unit: FAILED **");
        $finish;
      end
    end
  end

endmodule
